// ===== src/lcg_rng_pkg.sv =====
// ----------------------------------------------------------------------------
// lcg_rng_pkg
// Shared types and constants of the LCG random range generator: generator
// constants, command codes, controller states and the command/status structs.
// ----------------------------------------------------------------------------
package lcg_rng_pkg;

  localparam int SEED_W = 16;
  localparam int DATA_W = 31;
  localparam int STEP_W = 5;

  // generator step: seed = seed * 65277 + 13489 (mod 2^16)
  localparam logic [SEED_W-1:0] LCG_MUL    = 16'hFEFD;
  localparam logic [SEED_W-1:0] LCG_ADD    = 16'h34B1;
  localparam logic [SEED_W-1:0] SEED_RESET = 16'h1211;
  localparam logic [DATA_W-1:0] CEIL_RESET = 31'd32767;

  // divider step counts: full-width divide and 16-bit seed divide
  localparam logic [STEP_W-1:0] DIV_STEPS_FULL = 5'd31;
  localparam logic [STEP_W-1:0] DIV_STEPS_SEED = 5'd16;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_RAW   = 2'd1,
    CMD_RANGE = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DIV_CEIL,
    ST_ADV_DRAW,
    ST_DIV_SEED
  } state_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_ERROR,
    RES_SEED,
    RES_QUOT
  } res_sel_t;

  typedef enum logic {
    DIV_CEIL,
    DIV_SEED
  } div_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     seed_load;
    logic     seed_adv;
    logic     div_start;
    div_sel_t div_sel;
    logic     div_latch;
    logic     emit;
    res_sel_t res_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       range_bad;
    logic       div_done;
    logic       quot_ok;
  } dp_status_t;

endpackage

// ===== src/lcg_rng_div.sv =====
// ----------------------------------------------------------------------------
// lcg_rng_div
// Restoring serial divider, one quotient bit per cycle. The step count is
// given at load; the dividend is left-aligned so a short divide of a narrow
// value leaves its quotient in the low bits. done pulses for one cycle once
// the quotient is final.
// ----------------------------------------------------------------------------
module lcg_rng_div
  import lcg_rng_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  input  logic [STEP_W-1:0] steps,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  logic [DATA_W-1:0] q_r, q_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] d_r;
  logic [STEP_W-1:0] cnt_r;
  logic              done_r;
  logic [DATA_W+1:0] diff;
  logic              ge;

  // one restoring step: shift in the next dividend bit and try to subtract
  assign diff    = {1'b0, rem_r, q_r[DATA_W-1]} - {2'b00, d_r};
  assign ge      = ~diff[DATA_W+1];
  assign rem_nxt = ge ? diff[DATA_W-1:0] : {rem_r[DATA_W-2:0], q_r[DATA_W-1]};
  assign q_nxt   = {q_r[DATA_W-2:0], ge};

  // control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (load) begin
      cnt_r  <= steps;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == STEP_W'(1));
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - STEP_W'(1);
      end
    end
  end

  // operand registers
  always_ff @(posedge clk) begin
    if (load) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (cnt_r != '0) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== src/lcg_rng_dp.sv =====
// ----------------------------------------------------------------------------
// lcg_rng_dp
// Datapath: transaction registers, seed and generator step, ceiling register,
// range divisor, shared serial divider and the result registers.
// ----------------------------------------------------------------------------
module lcg_rng_dp
  import lcg_rng_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ctrl_cmd_t         ctrl,
  output dp_status_t        status,
  input  logic [1:0]        in_command,
  input  logic [SEED_W-1:0] in_seed_value,
  input  logic [DATA_W-1:0] in_range_limit,
  input  logic              cfg_wr_en,
  input  logic [DATA_W-1:0] cfg_wr_data,
  output logic              out_strobe,
  output logic [DATA_W-1:0] out_value,
  output logic              out_error
);

  logic [1:0]        cmd_r;
  logic [SEED_W-1:0] seed_in_r;
  logic [DATA_W-1:0] range_r;
  logic [SEED_W-1:0] seed_r;
  logic [SEED_W-1:0] seed_adv;
  logic [DATA_W-1:0] ceiling_r;
  logic [DATA_W-1:0] divisor_r;
  logic              strobe_r;
  logic [DATA_W-1:0] value_r, value_nxt;
  logic              error_r;
  logic [DATA_W-1:0] div_dividend;
  logic [DATA_W-1:0] div_divisor;
  logic [STEP_W-1:0] div_steps;
  logic              div_done;
  logic [DATA_W-1:0] div_quot;

  // captured transaction
  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      cmd_r     <= in_command;
      seed_in_r <= in_seed_value;
      range_r   <= in_range_limit;
    end
  end

  // generator step, low 16 bits of the product
  assign seed_adv = seed_r * LCG_MUL + LCG_ADD;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else if (ctrl.seed_load) begin
      seed_r <= seed_in_r;
    end else if (ctrl.seed_adv) begin
      seed_r <= seed_adv;
    end
  end

  // ceiling register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceiling_r <= CEIL_RESET;
    end else if (cfg_wr_en) begin
      ceiling_r <= cfg_wr_data;
    end
  end

  // divider operand selection
  always_comb begin
    case (ctrl.div_sel)
      DIV_CEIL: begin
        div_dividend = ceiling_r;
        div_divisor  = range_r;
        div_steps    = DIV_STEPS_FULL;
      end
      DIV_SEED: begin
        div_dividend = {seed_adv, (DATA_W-SEED_W)'(0)};
        div_divisor  = divisor_r;
        div_steps    = DIV_STEPS_SEED;
      end
      default: begin
        div_dividend = ceiling_r;
        div_divisor  = range_r;
        div_steps    = DIV_STEPS_FULL;
      end
    endcase
  end

  lcg_rng_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (ctrl.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_quot)
  );

  // range divisor
  always_ff @(posedge clk) begin
    if (ctrl.div_latch) begin
      divisor_r <= div_quot;
    end
  end

  // status to the controller
  assign status.cmd       = cmd_r;
  assign status.range_bad = (range_r == '0) || (range_r > ceiling_r);
  assign status.div_done  = div_done;
  assign status.quot_ok   = (div_quot < range_r);

  // result selection
  always_comb begin
    case (ctrl.res_sel)
      RES_ZERO:  value_nxt = '0;
      RES_ERROR: value_nxt = '0;
      RES_SEED:  value_nxt = DATA_W'(seed_adv);
      RES_QUOT:  value_nxt = div_quot;
      default:   value_nxt = '0;
    endcase
  end

  // result registers, strobe for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      value_r <= value_nxt;
      error_r <= (ctrl.res_sel == RES_ERROR);
    end
  end

  assign out_strobe = strobe_r;
  assign out_value  = value_r;
  assign out_error  = error_r;

endmodule

// ===== src/lcg_rng_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcg_rng_ctrl
// Controller: sequences seed loads, raw draws and the range draw with its
// divisor computation and rejection retries.
// ----------------------------------------------------------------------------
module lcg_rng_ctrl
  import lcg_rng_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  dp_status_t status,
  output ctrl_cmd_t  ctrl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (status.cmd == CMD_RANGE && !status.range_bad) begin
          state_nxt = ST_DIV_CEIL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV_CEIL: begin
        if (status.div_done) state_nxt = ST_ADV_DRAW;
      end
      ST_ADV_DRAW: begin
        state_nxt = ST_DIV_SEED;
      end
      ST_DIV_SEED: begin
        if (status.div_done) begin
          state_nxt = status.quot_ok ? ST_IDLE : ST_ADV_DRAW;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl = '0;
    ctrl.div_sel = DIV_CEIL;
    ctrl.res_sel = RES_ZERO;
    case (state_r)
      ST_IDLE: begin
        ctrl.load_in = start;
      end
      ST_DISPATCH: begin
        case (status.cmd)
          CMD_LOAD: begin
            ctrl.seed_load = 1'b1;
            ctrl.emit      = 1'b1;
          end
          CMD_RAW: begin
            ctrl.seed_adv = 1'b1;
            ctrl.emit     = 1'b1;
            ctrl.res_sel  = RES_SEED;
          end
          CMD_RANGE: begin
            if (status.range_bad) begin
              ctrl.emit    = 1'b1;
              ctrl.res_sel = RES_ERROR;
            end else begin
              ctrl.div_start = 1'b1;
            end
          end
          default: begin
            ctrl.emit = 1'b1;
          end
        endcase
      end
      ST_DIV_CEIL: begin
        ctrl.div_latch = status.div_done;
      end
      ST_ADV_DRAW: begin
        ctrl.seed_adv  = 1'b1;
        ctrl.div_start = 1'b1;
        ctrl.div_sel   = DIV_SEED;
      end
      ST_DIV_SEED: begin
        ctrl.div_sel = DIV_SEED;
        if (status.div_done && status.quot_ok) begin
          ctrl.emit    = 1'b1;
          ctrl.res_sel = RES_QUOT;
        end
      end
      default: begin
        ctrl.load_in = 1'b0;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== src/lcg_random_range_generator.sv =====
// ----------------------------------------------------------------------------
// lcg_random_range_generator
// 16-bit linear congruential generator with a rejection-based range draw.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; each transaction
// gives exactly one result on out_value/out_error, shown for one cycle with
// out_strobe, and the receiver cannot stall it. A seed load, a raw draw, an
// unused command and a refused range draw are settled in the dispatch state,
// and the result is registered from there. A range draw runs the shared
// one-bit-per-cycle divider: 31 steps for rand_ceiling / range_limit, then per
// attempt a seed step plus a 16-step divide of the seed; the number of attempts
// depends on the seed sequence. busy stays high until the result is issued, and
// a new transaction may start in the strobe cycle.
// cfg_wr_data sets rand_ceiling and is to be written only while idle.
// ----------------------------------------------------------------------------
module lcg_random_range_generator
  import lcg_rng_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_command,
  input  logic [SEED_W-1:0] in_seed_value,
  input  logic [DATA_W-1:0] in_range_limit,
  input  logic              cfg_wr_en,
  input  logic [DATA_W-1:0] cfg_wr_data,
  output logic              out_strobe,
  output logic [DATA_W-1:0] out_value,
  output logic              out_error
);

  ctrl_cmd_t  ctrl;
  dp_status_t status;

  // sequencing
  lcg_rng_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .ctrl   (ctrl)
  );

  // seed, divider and result registers
  lcg_rng_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .status         (status),
    .in_command     (in_command),
    .in_seed_value  (in_seed_value),
    .in_range_limit (in_range_limit),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_strobe     (out_strobe),
    .out_value      (out_value),
    .out_error      (out_error)
  );

endmodule

// ===== tb/sv/tb_lcg_random_range_generator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lcg_random_range_generator
// Self-checking bench for the LCG random range generator. A scoreboard class
// tracks the seed and rand_ceiling, predicts the value/error of each accepted
// transaction and compares it with the strobed result. Stimulus covers seed
// loads, raw draws, range draws (good and refused), the unused command and
// several rand_ceiling settings, with random sender gaps.
// ----------------------------------------------------------------------------
module tb_lcg_random_range_generator;
  import lcg_rng_pkg::*;

  localparam logic [1:0]        CMD_UNUSED   = 2'd3;
  localparam logic [DATA_W-1:0] CEIL_MAX     = 31'h7FFF_FFFF;
  localparam int                MAX_ADVANCES = 200;
  localparam int                TAIL_CYCLES  = 64;
  localparam int                PHASE_ITEMS  = 130;
  localparam int                NUM_PHASES   = 7;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              error;
  } draw_result_t;

  // tracks generator state and holds the expected results in order
  class lcg_draw_scoreboard;
    logic [SEED_W-1:0] seed;
    logic [DATA_W-1:0] ceiling;
    draw_result_t      expected_draws[$];
    int unsigned       mismatches;

    function new();
      seed       = SEED_RESET;
      ceiling    = CEIL_RESET;
      mismatches = 0;
    endfunction

    // rejection loop of a range draw; returns how many seed advances it took
    function int unsigned run_range_draw(inout logic [SEED_W-1:0] s,
                                         input logic [DATA_W-1:0] limit,
                                         output logic [DATA_W-1:0] quot);
      logic [DATA_W-1:0] divisor;
      int unsigned       n;
      divisor = ceiling / limit;
      n       = 0;
      do begin
        s    = s * LCG_MUL + LCG_ADD;
        n++;
        quot = {15'd0, s} / divisor;
      end while (quot >= limit && n <= 65536);
      return n;
    endfunction

    // predict the result of an accepted transaction
    function void note_command(logic [1:0] cmd, logic [SEED_W-1:0] new_seed,
                               logic [DATA_W-1:0] limit);
      draw_result_t r;
      logic [DATA_W-1:0] q;
      r = '0;
      case (cmd)
        CMD_LOAD: seed = new_seed;
        CMD_RAW: begin
          seed    = seed * LCG_MUL + LCG_ADD;
          r.value = {15'd0, seed};
        end
        CMD_RANGE: begin
          if (limit == 0 || limit > ceiling) begin
            r.error = 1'b1;
          end else begin
            void'(run_range_draw(seed, limit, q));
            r.value = q;
          end
        end
        default: ;
      endcase
      expected_draws.push_back(r);
    endfunction

    // compare a strobed result with the oldest expectation
    function void check_draw(logic [DATA_W-1:0] value, logic error);
      draw_result_t exp_r;
      if (expected_draws.size() == 0) begin
        $error("unexpected result: value %0d error %0d", value, error);
        mismatches++;
      end else begin
        exp_r = expected_draws.pop_front();
        if (value !== exp_r.value) begin
          $error("value mismatch: expected %0d, actual %0d", exp_r.value, value);
          mismatches++;
        end
        if (error !== exp_r.error) begin
          $error("error mismatch: expected %0d, actual %0d", exp_r.error, error);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_command;
  logic [SEED_W-1:0] in_seed_value;
  logic [DATA_W-1:0] in_range_limit;
  logic              cfg_wr_en;
  logic [DATA_W-1:0] cfg_wr_data;
  logic              out_strobe;
  logic [DATA_W-1:0] out_value;
  logic              out_error;

  lcg_draw_scoreboard sb;
  logic               idle_on;
  logic [SEED_W-1:0]  seed_before_zero;

  lcg_random_range_generator i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_seed_value  (in_seed_value),
    .in_range_limit (in_range_limit),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_strobe     (out_strobe),
    .out_value      (out_value),
    .out_error      (out_error)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // monitor: results checked before a transaction in the same cycle is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) sb.check_draw(out_value, out_error);
      if (start && !busy) sb.note_command(in_command, in_seed_value, in_range_limit);
      if (cfg_wr_en) sb.ceiling = cfg_wr_data;
    end
  end

  // drive one transaction from a falling edge, return at the falling edge after it
  task automatic send_item(logic [1:0] cmd, logic [SEED_W-1:0] sv,
                           logic [DATA_W-1:0] lim);
    while (idle_on && $urandom_range(99) < 25) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start          <= 1'b1;
    in_command     <= cmd;
    in_seed_value  <= sv;
    in_range_limit <= lim;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // long rejection runs are cut short by loading a friendlier seed first
  task automatic issue(logic [1:0] cmd, logic [SEED_W-1:0] sv,
                       logic [DATA_W-1:0] lim);
    logic [SEED_W-1:0] s;
    logic [SEED_W-1:0] s2;
    logic [DATA_W-1:0] q;
    if (cmd == CMD_RANGE && lim != 0 && lim <= sb.ceiling) begin
      s = sb.seed;
      if (sb.run_range_draw(s, lim, q) > MAX_ADVANCES) begin
        s2 = SEED_W'($urandom);
        s  = s2;
        if (sb.run_range_draw(s, lim, q) > MAX_ADVANCES) s2 = seed_before_zero;
        send_item(CMD_LOAD, s2, DATA_W'($urandom));
      end
    end
    send_item(cmd, sv, lim);
  endtask

  // hold off the sender until every expected result has arrived
  task automatic wait_drained();
    start <= 1'b0;
    while (sb.expected_draws.size() != 0) @(negedge clk);
  endtask

  task automatic write_ceiling(logic [DATA_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // random transaction weighted toward range draws
  task automatic random_item();
    int unsigned       r;
    int unsigned       p;
    logic [1:0]        cmd;
    logic [DATA_W-1:0] lim;
    r = $urandom_range(99);
    p = $urandom_range(99);
    if (r < 10)      cmd = CMD_LOAD;
    else if (r < 40) cmd = CMD_RAW;
    else if (r < 94) cmd = CMD_RANGE;
    else             cmd = CMD_UNUSED;
    if (p < 55)      lim = DATA_W'($urandom_range(sb.ceiling, 1));
    else if (p < 70) lim = DATA_W'($urandom_range(sb.ceiling < 16 ? sb.ceiling : 16, 1));
    else if (p < 78) lim = '0;
    else if (p < 90) lim = (sb.ceiling < CEIL_MAX) ?
                           DATA_W'($urandom_range(CEIL_MAX, sb.ceiling + 1)) : sb.ceiling;
    else             lim = DATA_W'($urandom);
    issue(cmd, SEED_W'($urandom), lim);
  endtask

  // stimulus
  initial begin
    logic [DATA_W-1:0] c;
    logic [SEED_W-1:0] s;
    start          = 1'b0;
    in_command     = CMD_LOAD;
    in_seed_value  = '0;
    in_range_limit = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    rst_n          = 1'b0;
    idle_on        = 1'b1;
    sb             = new();
    // seed whose next advance is 0, so a range draw ends at once
    seed_before_zero = '0;
    for (int i = 0; i < 65536; i++) begin
      s = SEED_W'(i);
      if (SEED_W'(s * LCG_MUL + LCG_ADD) == '0) seed_before_zero = s;
    end
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset seed, range edges, refusals, unused command, seed extremes
    issue(CMD_RAW, 16'h0000, '0);
    issue(CMD_RANGE, 16'hFFFF, '0);
    issue(CMD_RANGE, 16'h0000, 31'd1);
    issue(CMD_RANGE, 16'h0000, CEIL_RESET);
    issue(CMD_RANGE, 16'h0000, DATA_W'(CEIL_RESET + 1));
    issue(CMD_RANGE, 16'h0000, CEIL_MAX);
    issue(CMD_UNUSED, 16'hFFFF, CEIL_MAX);
    issue(CMD_LOAD, 16'h0000, CEIL_MAX);
    issue(CMD_RAW, 16'hFFFF, '0);
    issue(CMD_LOAD, 16'hFFFF, '0);
    issue(CMD_RAW, 16'h0000, '0);
    issue(CMD_LOAD, seed_before_zero, '0);
    issue(CMD_RANGE, 16'h0000, 31'd1);
    issue(CMD_RANGE, 16'h0000, 31'd100);

    // phases over several ceiling settings
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       c = 31'd1;
        1:       c = CEIL_MAX;
        2:       c = 31'd65535;
        3:       c = 31'd65536;
        4:       c = DATA_W'($urandom_range(4095, 1024));
        5:       c = DATA_W'($urandom_range(CEIL_MAX, 31'h0001_0000));
        default: c = CEIL_RESET;
      endcase
      wait_drained();
      write_ceiling(c);
      // one phase runs back to back with no sender gaps
      idle_on = (ph != 3);
      issue(CMD_RANGE, SEED_W'($urandom), c);
      if (c != CEIL_MAX) issue(CMD_RANGE, SEED_W'($urandom), DATA_W'(c + 1));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 1 && i == PHASE_ITEMS / 2) wait_drained();
        random_item();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("lcg_random_range_generator verification clean");
    end else begin
      $display("lcg_random_range_generator verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #150_000_000;
    $display("lcg_random_range_generator verification failed");
    $finish;
  end

endmodule
